/* hdl/mbad_pkg.sv */
package mbad_pkg;

    localparam int SPRITE_DEPTH = 2048;
    localparam int WORK_DEPTH   = 6144;
    localparam int SPRITE_AW    = $clog2(SPRITE_DEPTH);
    localparam int WORK_AW      = $clog2(WORK_DEPTH);

    // bus map
    localparam logic [15:0] ADDR_DIPB_LO   = 16'h1200;
    localparam logic [15:0] ADDR_DIPB_HI   = 16'h127f;
    localparam logic [15:0] ADDR_PORT_LO   = 16'h1280;
    localparam logic [15:0] ADDR_PORT_HI   = 16'h128f;
    localparam logic [15:0] ADDR_CTRL_LO   = 16'h1080;
    localparam logic [15:0] ADDR_CTRL_HI   = 16'h10ff;
    localparam logic [15:0] ADDR_LATCH_LO  = 16'h1100;
    localparam logic [15:0] ADDR_LATCH_HI  = 16'h117f;
    localparam logic [15:0] ADDR_SPRITE_LO = 16'h1800;
    localparam logic [15:0] ADDR_SPRITE_HI = 16'h1fff;
    localparam logic [15:0] ADDR_SCRL_A_LO = 16'h1840;
    localparam logic [15:0] ADDR_SCRL_A_HI = 16'h185f;
    localparam logic [15:0] ADDR_SCRL_B_LO = 16'h1c40;
    localparam logic [15:0] ADDR_SCRL_B_HI = 16'h1c5f;
    localparam logic [15:0] ADDR_WORK_LO   = 16'h2800;
    localparam logic [15:0] ADDR_WORK_HI   = 16'h3fff;
    localparam logic [15:0] ADDR_TILE_LO   = 16'h3000;
    localparam logic [15:0] ADDR_ROM_LO    = 16'h6000;
    localparam logic [10:0] TILE_MASK      = 11'h7ff;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // control register selects, address bits 2..0
    localparam logic [2:0] CTRL_FLIP = 3'd0;
    localparam logic [2:0] CTRL_TRIG = 3'd1;
    localparam logic [2:0] CTRL_IRQ  = 3'd7;

    // port selects, address bits 1..0
    localparam logic [1:0] PORT_SYSTEM = 2'd0;
    localparam logic [1:0] PORT_PLAYER = 2'd1;
    localparam logic [1:0] PORT_UNUSED = 2'd2;
    localparam logic [1:0] PORT_DIPA   = 2'd3;

    // config register indexes
    localparam logic CFG_DIP_A = 1'b0;
    localparam logic CFG_DIP_B = 1'b1;

    // read data sources
    localparam logic [1:0] RD_ZERO   = 2'd0;
    localparam logic [1:0] RD_DIRECT = 2'd1;
    localparam logic [1:0] RD_SPRITE = 2'd2;
    localparam logic [1:0] RD_WORK   = 2'd3;

    typedef struct packed {
        logic [1:0]           rd_sel;
        logic [7:0]           rd_direct;
        logic                 rom;
        logic                 sprite_we;
        logic [SPRITE_AW-1:0] sprite_waddr;
        logic [SPRITE_AW-1:0] sprite_raddr;
        logic                 work_we;
        logic [WORK_AW-1:0]   work_addr;
        logic                 flip_we;
        logic                 trig_we;
        logic                 irq_we;
        logic                 latch_we;
        logic                 scroll;
        logic                 scroll_hi;
        logic [4:0]           scroll_row;
        logic                 tile_dirty;
        logic [10:0]          tile_index;
        logic [7:0]           wdata;
    } t_dec;

endpackage

/* hdl/mbad_ram.sv */
module mbad_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mbad_decode.sv */
module mbad_decode import mbad_pkg::*; (
    input  logic        i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_player_port,
    input  logic [7:0]  i_unused_port,
    input  logic [7:0]  i_system_port,
    input  logic [7:0]  i_dip_a,
    input  logic [7:0]  i_dip_b,
    output t_dec        o_dec
);

    logic        is_wr;
    logic        in_dipb;
    logic        in_port;
    logic        in_ctrl;
    logic        in_latch;
    logic        in_sprite;
    logic        in_work;
    logic        in_rom;
    logic        in_scroll;
    logic [15:0] work_off;

    always_comb begin
        is_wr     = (i_kind == KIND_WRITE);
        in_dipb   = (i_address >= ADDR_DIPB_LO) && (i_address <= ADDR_DIPB_HI);
        in_port   = (i_address >= ADDR_PORT_LO) && (i_address <= ADDR_PORT_HI);
        in_ctrl   = (i_address >= ADDR_CTRL_LO) && (i_address <= ADDR_CTRL_HI);
        in_latch  = (i_address >= ADDR_LATCH_LO) && (i_address <= ADDR_LATCH_HI);
        in_sprite = (i_address >= ADDR_SPRITE_LO) && (i_address <= ADDR_SPRITE_HI);
        in_work   = (i_address >= ADDR_WORK_LO) && (i_address <= ADDR_WORK_HI);
        in_rom    = (i_address >= ADDR_ROM_LO);
        in_scroll = ((i_address >= ADDR_SCRL_A_LO) && (i_address <= ADDR_SCRL_A_HI))
                 || ((i_address >= ADDR_SCRL_B_LO) && (i_address <= ADDR_SCRL_B_HI));
        work_off  = i_address - ADDR_WORK_LO;

        o_dec = '0;
        o_dec.wdata        = i_write_data;
        o_dec.sprite_waddr = i_address[SPRITE_AW-1:0];
        o_dec.work_addr    = work_off[WORK_AW-1:0];
        o_dec.scroll_row   = i_address[4:0];
        o_dec.scroll_hi    = i_address[10];
        // a scroll write reads its partner byte in the other half
        o_dec.sprite_raddr = {i_address[SPRITE_AW-1] ^ is_wr, i_address[SPRITE_AW-2:0]};

        if (!is_wr) begin
            if (in_dipb) begin
                o_dec.rd_sel    = RD_DIRECT;
                o_dec.rd_direct = i_dip_b;
            end else if (in_port) begin
                o_dec.rd_sel = RD_DIRECT;
                case (i_address[1:0])
                    PORT_SYSTEM: o_dec.rd_direct = i_system_port;
                    PORT_PLAYER: o_dec.rd_direct = i_player_port;
                    PORT_UNUSED: o_dec.rd_direct = i_unused_port;
                    PORT_DIPA:   o_dec.rd_direct = i_dip_a;
                    default:     o_dec.rd_direct = '0;
                endcase
            end else if (in_sprite) begin
                o_dec.rd_sel = RD_SPRITE;
            end else if (in_work) begin
                o_dec.rd_sel = RD_WORK;
            end else if (in_rom) begin
                o_dec.rom = 1'b1;
            end
        end else begin
            if (in_ctrl) begin
                case (i_address[2:0])
                    CTRL_FLIP: o_dec.flip_we = 1'b1;
                    CTRL_TRIG: o_dec.trig_we = 1'b1;
                    CTRL_IRQ:  o_dec.irq_we  = 1'b1;
                    default:   ;
                endcase
            end else if (in_latch) begin
                o_dec.latch_we = 1'b1;
            end else if (in_sprite) begin
                o_dec.sprite_we = 1'b1;
                o_dec.scroll    = in_scroll;
            end else if (in_work) begin
                o_dec.work_we = 1'b1;
                if (i_address >= ADDR_TILE_LO) begin
                    o_dec.tile_dirty = 1'b1;
                    o_dec.tile_index = i_address[10:0] & TILE_MASK;
                end
            end
        end
    end

endmodule

/* hdl/main_bus_address_decoder_core.sv */
// results come out of stage two; stage one holds each transaction while the rams read
// throughput: one transaction per cycle unless busy; sprite and work ram each do
// one read and one write per cycle, and a write lands before the next transaction reads, so
// no forwarding is needed; reset: flags, latch and trigger clear at once, then a clearing
// pass zeroes both rams with busy high; config writes are taken during the pass
// the receiver cannot stall: o_valid marks each result for exactly one cycle
module main_bus_address_decoder_core import mbad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_player_port,
    input  logic [7:0]  i_unused_port,
    input  logic [7:0]  i_system_port,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // result channel
    output logic        o_valid,
    output logic [7:0]  o_read_data,
    output logic        o_rom_access,
    output logic        o_flip_screen,
    output logic        o_irq_enable,
    output logic        o_sound_irq_request,
    output logic [7:0]  o_sound_command,
    output logic        o_scroll_update,
    output logic [4:0]  o_scroll_row,
    output logic [8:0]  o_scroll_value,
    output logic        o_tile_dirty,
    output logic [10:0] o_tile_index
);

    localparam logic [WORK_AW-1:0] CLR_LAST = WORK_AW'(WORK_DEPTH - 1);
    localparam logic [WORK_AW-1:0] CLR_STEP = WORK_AW'(1);

    // config registers
    logic [7:0] r_dip_a;
    logic [7:0] r_dip_b;

    // flags and sound state
    logic       r_flip;
    logic       r_irq_en;
    logic [7:0] r_trig;
    logic [7:0] r_latch;

    // clearing pass
    logic               r_clearing;
    logic [WORK_AW-1:0] r_clr_cnt;

    // stage one: decoded transaction waiting for ram data
    logic r_s1_valid;
    t_dec r_s1;
    logic r_s1_snd_irq;

    // stage two: output registers
    logic        r_o_valid;
    logic [7:0]  r_o_read_data;
    logic        r_o_rom;
    logic        r_o_flip;
    logic        r_o_irq_en;
    logic        r_o_snd_irq;
    logic [7:0]  r_o_latch;
    logic        r_o_scroll;
    logic [4:0]  r_o_row;
    logic [8:0]  r_o_scroll_val;
    logic        r_o_tile;
    logic [10:0] r_o_tile_idx;

    t_dec dec;
    logic accept;

    // ram ports
    logic                 spr_we;
    logic [SPRITE_AW-1:0] spr_waddr;
    logic [7:0]           spr_wdata;
    logic [7:0]           spr_rdata;
    logic                 wrk_we;
    logic [WORK_AW-1:0]   wrk_addr;
    logic [7:0]           wrk_wdata;
    logic [7:0]           wrk_rdata;

    logic [7:0] n_read_data;
    logic [8:0] n_scroll_val;

    mbad_decode u_decode (
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_player_port (i_player_port),
        .i_unused_port (i_unused_port),
        .i_system_port (i_system_port),
        .i_dip_a       (r_dip_a),
        .i_dip_b       (r_dip_b),
        .o_dec         (dec)
    );

    assign busy   = r_clearing;
    assign accept = start && !r_clearing;

    // the clearing pass owns the write ports; no transaction is taken meanwhile
    always_comb begin
        if (r_clearing) begin
            spr_we    = 1'b1;
            spr_waddr = r_clr_cnt[SPRITE_AW-1:0];
            spr_wdata = '0;
            wrk_we    = 1'b1;
            wrk_addr  = r_clr_cnt;
            wrk_wdata = '0;
        end else begin
            spr_we    = accept && dec.sprite_we;
            spr_waddr = dec.sprite_waddr;
            spr_wdata = dec.wdata;
            wrk_we    = accept && dec.work_we;
            wrk_addr  = dec.work_addr;
            wrk_wdata = dec.wdata;
        end
    end

    mbad_ram #(.DEPTH(SPRITE_DEPTH), .WIDTH(8)) u_sprite_ram (
        .i_clk   (i_clk),
        .i_we    (spr_we),
        .i_waddr (spr_waddr),
        .i_wdata (spr_wdata),
        .i_raddr (dec.sprite_raddr),
        .o_rdata (spr_rdata)
    );

    // work ram reads and writes at one address; a read transaction never writes
    mbad_ram #(.DEPTH(WORK_DEPTH), .WIDTH(8)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (wrk_we),
        .i_waddr (wrk_addr),
        .i_wdata (wrk_wdata),
        .i_raddr (wrk_addr),
        .o_rdata (wrk_rdata)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a <= '0;
            r_dip_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIP_A: r_dip_a <= i_cfg_data;
                CFG_DIP_B: r_dip_b <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + CLR_STEP;
            if (r_clr_cnt == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // flags, trigger and latch update at accept so the result sees the state after the access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip   <= 1'b0;
            r_irq_en <= 1'b0;
            r_trig   <= '0;
            r_latch  <= '0;
        end else if (accept) begin
            if (dec.flip_we) begin
                r_flip <= dec.wdata[0];
            end
            if (dec.irq_we) begin
                r_irq_en <= (dec.wdata != '0);
            end
            if (dec.trig_we) begin
                r_trig <= dec.wdata;
            end
            if (dec.latch_we) begin
                r_latch <= dec.wdata;
            end
        end
    end

    // stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1         <= dec;
            // sound irq on a zero to nonzero trigger transition
            r_s1_snd_irq <= dec.trig_we && (r_trig == '0) && (dec.wdata != '0);
        end
    end

    // merge ram data
    always_comb begin
        case (r_s1.rd_sel)
            RD_DIRECT: n_read_data = r_s1.rd_direct;
            RD_SPRITE: n_read_data = spr_rdata;
            RD_WORK:   n_read_data = wrk_rdata;
            default:   n_read_data = '0;
        endcase
        // low byte lives in the lower half, bit 8 in bit 0 of the upper half
        if (r_s1.scroll_hi) begin
            n_scroll_val = {r_s1.wdata[0], spr_rdata};
        end else begin
            n_scroll_val = {spr_rdata[0], r_s1.wdata};
        end
    end

    // stage two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_o_read_data  <= n_read_data;
            r_o_rom        <= r_s1.rom;
            r_o_flip       <= r_flip;
            r_o_irq_en     <= r_irq_en;
            r_o_snd_irq    <= r_s1_snd_irq;
            r_o_latch      <= r_latch;
            r_o_scroll     <= r_s1.scroll;
            r_o_row        <= r_s1.scroll ? r_s1.scroll_row : 5'd0;
            r_o_scroll_val <= r_s1.scroll ? n_scroll_val : 9'd0;
            r_o_tile       <= r_s1.tile_dirty;
            r_o_tile_idx   <= r_s1.tile_index;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_read_data         = r_o_read_data;
    assign o_rom_access        = r_o_rom;
    assign o_flip_screen       = r_o_flip;
    assign o_irq_enable        = r_o_irq_en;
    assign o_sound_irq_request = r_o_snd_irq;
    assign o_sound_command     = r_o_latch;
    assign o_scroll_update     = r_o_scroll;
    assign o_scroll_row        = r_o_row;
    assign o_scroll_value      = r_o_scroll_val;
    assign o_tile_dirty        = r_o_tile;
    assign o_tile_index        = r_o_tile_idx;

endmodule

/* hdl/mbad_checker.sv */
module mbad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [7:0]  o_read_data,
    input logic        o_rom_access,
    input logic        o_scroll_update,
    input logic [4:0]  o_scroll_row,
    input logic [8:0]  o_scroll_value,
    input logic        o_tile_dirty
);

    // reset always starts the clearing pass
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // every accepted transaction gives a result once through stage one and stage two
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing for accepted transaction");

    // a result needs a transaction accepted ahead of it through stage one and stage two
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without transaction");

    // one write cannot hit scroll and tile space, and rom reads return zero
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_scroll_update && o_tile_dirty) && !(o_rom_access && o_read_data != 8'd0))
        else $error("conflicting result flags");

    a_scroll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_scroll_update) |-> (o_scroll_row == 5'd0 && o_scroll_value == 9'd0))
        else $error("scroll fields set without update");

endmodule

bind main_bus_address_decoder_core mbad_checker u_mbad_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_read_data     (o_read_data),
    .o_rom_access    (o_rom_access),
    .o_scroll_update (o_scroll_update),
    .o_scroll_row    (o_scroll_row),
    .o_scroll_value  (o_scroll_value),
    .o_tile_dirty    (o_tile_dirty)
);

/* bench/tb_main_bus_address_decoder_core.sv */
`timescale 1ns / 1ps

module tb_main_bus_address_decoder_core;
    import mbad_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int RECENT_DEPTH = 16;
    // row bases of the two scroll halves inside sprite ram
    localparam logic [10:0] SCROLL_LO_OFS = 11'(ADDR_SCRL_A_LO - ADDR_SPRITE_LO);
    localparam logic [10:0] SCROLL_HI_OFS = 11'(ADDR_SCRL_B_LO - ADDR_SPRITE_LO);

    // one bus result as the block presents it
    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_access;
        logic        flip_screen;
        logic        irq_enable;
        logic        sound_irq;
        logic [7:0]  sound_command;
        logic        scroll_update;
        logic [4:0]  scroll_row;
        logic [8:0]  scroll_value;
        logic        tile_dirty;
        logic [10:0] tile_index;
    } t_bus_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic [7:0]  i_player_port;
    logic [7:0]  i_unused_port;
    logic [7:0]  i_system_port;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic        o_rom_access;
    logic        o_flip_screen;
    logic        o_irq_enable;
    logic        o_sound_irq_request;
    logic [7:0]  o_sound_command;
    logic        o_scroll_update;
    logic [4:0]  o_scroll_row;
    logic [8:0]  o_scroll_value;
    logic        o_tile_dirty;
    logic [10:0] o_tile_index;

    // shadow copy of the board state
    logic [7:0]  dip_a_shadow;
    logic [7:0]  dip_b_shadow;
    logic [7:0]  sprite_mem [SPRITE_DEPTH];
    logic [7:0]  work_mem [WORK_DEPTH];
    logic        flip_state;
    logic        irq_en_state;
    logic [7:0]  trigger_state;
    logic [7:0]  latch_state;

    // predicted results waiting for their strobe, oldest first
    t_bus_result pending_results [$];
    // addresses written lately, reused to read back fresh data
    logic [15:0] recent_writes [$];

    int fail_count = 0;
    int cycle_count = 0;
    int reads_sent = 0;
    int writes_sent = 0;
    int rom_hits = 0;
    int scroll_hits = 0;
    int tile_hits = 0;
    int sound_irqs = 0;

    main_bus_address_decoder_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_kind              (i_kind),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .i_player_port       (i_player_port),
        .i_unused_port       (i_unused_port),
        .i_system_port       (i_system_port),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_read_data         (o_read_data),
        .o_rom_access        (o_rom_access),
        .o_flip_screen       (o_flip_screen),
        .o_irq_enable        (o_irq_enable),
        .o_sound_irq_request (o_sound_irq_request),
        .o_sound_command     (o_sound_command),
        .o_scroll_update     (o_scroll_update),
        .o_scroll_row        (o_scroll_row),
        .o_scroll_value      (o_scroll_value),
        .o_tile_dirty        (o_tile_dirty),
        .o_tile_index        (o_tile_index)
    );

    always #6 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost strobe ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // decode one bus access against the shadow state and update it
    function automatic t_bus_result predict_access(input logic kind, input logic [15:0] a,
                                                   input logic [7:0] wd,
                                                   input logic [7:0] pp,
                                                   input logic [7:0] up,
                                                   input logic [7:0] sp);
        t_bus_result r;
        logic [4:0]  row;
        r = '0;
        if (kind == KIND_READ) begin
            if (a >= ADDR_DIPB_LO && a <= ADDR_DIPB_HI) begin
                r.read_data = dip_b_shadow;
            end else if (a >= ADDR_PORT_LO && a <= ADDR_PORT_HI) begin
                case (a[1:0])
                    PORT_SYSTEM: r.read_data = sp;
                    PORT_PLAYER: r.read_data = pp;
                    PORT_UNUSED: r.read_data = up;
                    default:     r.read_data = dip_a_shadow;
                endcase
            end else if (a >= ADDR_SPRITE_LO && a <= ADDR_SPRITE_HI) begin
                r.read_data = sprite_mem[a[10:0]];
            end else if (a >= ADDR_WORK_LO && a <= ADDR_WORK_HI) begin
                r.read_data = work_mem[int'(a - ADDR_WORK_LO)];
            end else if (a >= ADDR_ROM_LO) begin
                r.rom_access = 1'b1;
            end
        end else begin
            if (a >= ADDR_CTRL_LO && a <= ADDR_CTRL_HI) begin
                case (a[2:0])
                    CTRL_FLIP: flip_state = wd[0];
                    CTRL_TRIG: begin
                        // sound irq only on a zero to nonzero step of the trigger
                        if (trigger_state == 8'h00 && wd != 8'h00)
                            r.sound_irq = 1'b1;
                        trigger_state = wd;
                    end
                    CTRL_IRQ:  irq_en_state = (wd != 8'h00);
                    default: ;
                endcase
            end else if (a >= ADDR_LATCH_LO && a <= ADDR_LATCH_HI) begin
                latch_state = wd;
            end else if (a >= ADDR_SPRITE_LO && a <= ADDR_SPRITE_HI) begin
                sprite_mem[a[10:0]] = wd;
                if ((a >= ADDR_SCRL_A_LO && a <= ADDR_SCRL_A_HI) ||
                    (a >= ADDR_SCRL_B_LO && a <= ADDR_SCRL_B_HI)) begin
                    row = a[4:0];
                    r.scroll_update = 1'b1;
                    r.scroll_row    = row;
                    r.scroll_value  = {sprite_mem[SCROLL_HI_OFS + 11'(row)][0],
                                       sprite_mem[SCROLL_LO_OFS + 11'(row)]};
                end
            end else if (a >= ADDR_WORK_LO && a <= ADDR_WORK_HI) begin
                work_mem[int'(a - ADDR_WORK_LO)] = wd;
                if (a >= ADDR_TILE_LO) begin
                    r.tile_dirty = 1'b1;
                    r.tile_index = a[10:0] & TILE_MASK;
                end
            end
        end
        r.flip_screen   = flip_state;
        r.irq_enable    = irq_en_state;
        r.sound_command = latch_state;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // result checker: every strobe retires the oldest prediction
    always @(posedge i_clk) begin
        t_bus_result want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", 16'(want.read_data), 16'(o_read_data));
                check_field("rom_access", 16'(want.rom_access), 16'(o_rom_access));
                check_field("flip_screen", 16'(want.flip_screen), 16'(o_flip_screen));
                check_field("irq_enable", 16'(want.irq_enable), 16'(o_irq_enable));
                check_field("sound_irq_request", 16'(want.sound_irq),
                            16'(o_sound_irq_request));
                check_field("sound_command", 16'(want.sound_command),
                            16'(o_sound_command));
                check_field("scroll_update", 16'(want.scroll_update),
                            16'(o_scroll_update));
                check_field("scroll_row", 16'(want.scroll_row), 16'(o_scroll_row));
                check_field("scroll_value", 16'(want.scroll_value), 16'(o_scroll_value));
                check_field("tile_dirty", 16'(want.tile_dirty), 16'(o_tile_dirty));
                check_field("tile_index", 16'(want.tile_index), 16'(o_tile_index));
            end
        end
    end

    // present one transaction and hold it until the block takes it
    task automatic send_access(input logic kind, input logic [15:0] a, input logic [7:0] wd,
                               input logic [7:0] pp, input logic [7:0] up,
                               input logic [7:0] sp);
        t_bus_result r;
        start         <= 1'b1;
        i_kind        <= kind;
        i_address     <= a;
        i_write_data  <= wd;
        i_player_port <= pp;
        i_unused_port <= up;
        i_system_port <= sp;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        r = predict_access(kind, a, wd, pp, up, sp);
        pending_results.insert(pending_results.size(), r);
        if (kind == KIND_WRITE) begin
            writes_sent++;
            recent_writes.insert(recent_writes.size(), a);
            if (recent_writes.size() > RECENT_DEPTH)
                void'(recent_writes.pop_front());
        end else begin
            reads_sent++;
        end
        rom_hits    += int'(r.rom_access);
        scroll_hits += int'(r.scroll_update);
        tile_hits   += int'(r.tile_dirty);
        sound_irqs  += int'(r.sound_irq);
    endtask

    // sender gap; start drops only when there really is a gap
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // always moves on by at least one edge so start is never driven twice in one step
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // dip banks are only touched with nothing in flight
    task automatic write_dip(input logic idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DIP_A)
            dip_a_shadow = val;
        else
            dip_b_shadow = val;
        @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int s;
        s = $urandom_range(0, 99);
        if (s < 55) return 0;
        if (s < 85) return $urandom_range(1, 3);
        if (s < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // zero and all-ones show up often so trigger edges and flags move
    function automatic logic [7:0] pick_byte();
        int s;
        s = $urandom_range(0, 99);
        if (s < 15) return 8'h00;
        if (s < 25) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // address mix weighted toward the interesting parts of the map
    function automatic logic [15:0] pick_address();
        int          s;
        logic [15:0] a;
        s = $urandom_range(0, 99);
        if (s < 6) begin
            a = 16'($urandom_range(ADDR_DIPB_LO, ADDR_DIPB_HI));
        end else if (s < 14) begin
            a = 16'($urandom_range(ADDR_PORT_LO, ADDR_PORT_HI));
        end else if (s < 26) begin
            a = 16'($urandom_range(ADDR_CTRL_LO, ADDR_CTRL_HI));
            // mostly hit the three live control selects
            case ($urandom_range(0, 3))
                0: a[2:0] = CTRL_FLIP;
                1: a[2:0] = CTRL_TRIG;
                2: a[2:0] = CTRL_IRQ;
                default: ;
            endcase
        end else if (s < 32) begin
            a = 16'($urandom_range(ADDR_LATCH_LO, ADDR_LATCH_HI));
        end else if (s < 50) begin
            a = ($urandom_range(0, 1) != 0) ? ADDR_SCRL_A_LO : ADDR_SCRL_B_LO;
            a = a + 16'($urandom_range(0, 31));
        end else if (s < 58) begin
            a = 16'($urandom_range(ADDR_SPRITE_LO, ADDR_SPRITE_HI));
        end else if (s < 68) begin
            a = 16'($urandom_range(ADDR_WORK_LO, ADDR_WORK_HI));
        end else if (s < 78) begin
            a = 16'($urandom_range(ADDR_TILE_LO, ADDR_WORK_HI));
        end else if (s < 84) begin
            a = 16'($urandom_range(ADDR_ROM_LO, 16'hffff));
        end else if (s < 90 || recent_writes.size() == 0) begin
            a = 16'($urandom_range(0, 16'hffff));
        end else begin
            a = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        end
        return a;
    endfunction

    // flags, latch and ram come up zero; ports and dip banks read back right
    task automatic test_reset_state();
        send_access(KIND_READ, 16'h1800, 8'h00, 8'hff, 8'h00, 8'hff);
        send_access(KIND_READ, ADDR_WORK_HI, 8'h00, 8'h00, 8'hff, 8'h00);
        send_access(KIND_READ, ADDR_PORT_LO, 8'h00, 8'h00, 8'h00, 8'hff);
        send_access(KIND_READ, ADDR_PORT_LO + 16'd1, 8'h00, 8'hff, 8'h00, 8'h00);
        send_access(KIND_READ, ADDR_PORT_LO + 16'd2, 8'h00, 8'h00, 8'hff, 8'h00);
        send_access(KIND_READ, ADDR_PORT_HI, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_READ, ADDR_DIPB_HI, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // walk the map edges and every write target at least once
    task automatic test_map_edges();
        send_access(KIND_READ, 16'h0000, 8'hff, 8'h5a, 8'ha5, 8'h3c);
        send_access(KIND_READ, ADDR_CTRL_LO, 8'h00, 8'hff, 8'hff, 8'hff);
        send_access(KIND_READ, ADDR_LATCH_HI, 8'h00, 8'hff, 8'hff, 8'hff);
        // flip takes data bit 0 only
        send_access(KIND_WRITE, ADDR_CTRL_LO, 8'hff, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_CTRL_LO, 8'hfe, 8'h00, 8'h00, 8'h00);
        // irq enable follows any nonzero byte
        send_access(KIND_WRITE, ADDR_CTRL_HI, 8'h80, 8'h00, 8'h00, 8'h00);
        // unused control select is ignored
        send_access(KIND_WRITE, ADDR_CTRL_LO + 16'd2, 8'hff, 8'h00, 8'h00, 8'h00);
        // sound trigger: zero stays quiet, rising edge fires, held nonzero does not
        send_access(KIND_WRITE, ADDR_CTRL_LO + 16'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_CTRL_LO + 16'd1, 8'h5a, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_CTRL_LO + 16'd1, 8'hff, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_CTRL_LO + 16'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_CTRL_LO + 16'd1, 8'h01, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_LATCH_LO, 8'ha5, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_LATCH_HI, 8'h3c, 8'h00, 8'h00, 8'h00);
        // scroll rows at both ends of both halves
        send_access(KIND_WRITE, ADDR_SCRL_A_LO, 8'hff, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_SCRL_B_LO, 8'h01, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_SCRL_B_HI, 8'hfe, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_SCRL_A_HI, 8'h80, 8'h00, 8'h00, 8'h00);
        // write then read straight after: the read must see the new byte
        send_access(KIND_WRITE, ADDR_SPRITE_HI, 8'h77, 8'h00, 8'h00, 8'h00);
        send_access(KIND_READ, ADDR_SPRITE_HI, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_WORK_LO, 8'h11, 8'h00, 8'h00, 8'h00);
        send_access(KIND_READ, ADDR_WORK_LO, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_TILE_LO, 8'hc3, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_WORK_HI, 8'h99, 8'h00, 8'h00, 8'h00);
        send_access(KIND_READ, ADDR_WORK_HI, 8'h00, 8'h00, 8'h00, 8'h00);
        // rom space flagged on reads, writes there and into dip and port space dropped
        send_access(KIND_READ, ADDR_ROM_LO, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_READ, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_READ, ADDR_ROM_LO - 16'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, 16'hffff, 8'h55, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_DIPB_LO, 8'h55, 8'h00, 8'h00, 8'h00);
        send_access(KIND_WRITE, ADDR_PORT_HI, 8'h55, 8'h00, 8'h00, 8'h00);
    endtask

    // several dip settings, extremes included; each bank read at two addresses
    task automatic test_dip_settings();
        logic [7:0] settings [5];
        settings = '{8'h00, 8'hff, 8'h55, 8'haa, 8'($urandom_range(0, 255))};
        foreach (settings[k]) begin
            wait_drained();
            write_dip(CFG_DIP_A, settings[k]);
            write_dip(CFG_DIP_B, ~settings[k]);
            send_access(KIND_READ, ADDR_DIPB_LO, 8'h00, 8'h00, 8'h00, 8'h00);
            send_access(KIND_READ, ADDR_DIPB_HI, 8'h00, 8'h00, 8'h00, 8'h00);
            send_access(KIND_READ, ADDR_PORT_LO + 16'd3, 8'h00, 8'h00, 8'h00, 8'h00);
            send_access(KIND_READ, ADDR_PORT_HI, 8'h00, 8'h00, 8'h00, 8'h00);
        end
    endtask

    // random traffic; back_to_back phases let start drop only for the halfway drain
    task automatic test_random_traffic(input int items, input logic back_to_back);
        logic kind;
        for (int n = 0; n < items; n++) begin
            // halfway through, let the pipe run dry once
            if (n == items / 2)
                wait_drained();
            kind = ($urandom_range(0, 99) < 55) ? KIND_WRITE : KIND_READ;
            send_access(kind, pick_address(), pick_byte(), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (!back_to_back)
                idle_cycles(pick_gap());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_kind        <= KIND_READ;
        i_address     <= '0;
        i_write_data  <= '0;
        i_player_port <= '0;
        i_unused_port <= '0;
        i_system_port <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_DIP_A;
        i_cfg_data    <= '0;
        dip_a_shadow  = '0;
        dip_b_shadow  = '0;
        flip_state    = 1'b0;
        irq_en_state  = 1'b0;
        trigger_state = '0;
        latch_state   = '0;
        foreach (sprite_mem[k]) sprite_mem[k] = '0;
        foreach (work_mem[k]) work_mem[k] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // dip banks can be loaded while the rams are still being cleared
        write_dip(CFG_DIP_A, 8'h96);
        write_dip(CFG_DIP_B, 8'h69);
        test_reset_state();
        test_map_edges();
        test_dip_settings();

        // random phases, dip banks changed between them with the pipe empty
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0: begin write_dip(CFG_DIP_A, 8'h00); write_dip(CFG_DIP_B, 8'hff); end
                1: begin write_dip(CFG_DIP_A, 8'hff); write_dip(CFG_DIP_B, 8'h00); end
                default: begin
                    write_dip(CFG_DIP_A, 8'($urandom_range(0, 255)));
                    write_dip(CFG_DIP_B, 8'($urandom_range(0, 255)));
                end
            endcase
            test_random_traffic(RANDOM_ITEMS / 4, p[0]);
        end

        wait_drained();
        // room for any stray strobe after the last expected one
        repeat (8) @(posedge i_clk);

        $display("covered %0d reads (%0d in rom space) and %0d writes",
                 reads_sent, rom_hits, writes_sent);
        $display("with %0d scroll row updates, %0d tile dirty marks, %0d sound irqs",
                 scroll_hits, tile_hits, sound_irqs);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/mbad_pkg.sv
hdl/mbad_ram.sv
hdl/mbad_decode.sv
hdl/main_bus_address_decoder_core.sv
hdl/mbad_checker.sv
bench/tb_main_bus_address_decoder_core.sv
